[rtl/wfmh_pkg.sv]
// Shared types and constants for the whitespace-filtered MurmurHash2 block.
package wfmh_pkg;

  localparam logic [31:0] MIX_MUL   = 32'h5bd1e995;
  localparam int          MIX_SHIFT = 24;
  localparam int          FIN_SHIFT_A = 13;
  localparam int          FIN_SHIFT_B = 15;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam int CMD_DEPTH = 4;

  // One unit of work for the hash engine.
  typedef struct packed {
    logic        start;     // first command of a message, load seed
    logic [31:0] seed;
    logic        has_word;  // mix a full 32-bit word
    logic [31:0] word;
    logic        is_final;  // fold tail and finish
    logic [23:0] tail;
    logic [1:0]  tail_cnt;
    logic        mismatch;
  } wfmh_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_K1,
    ST_K2,
    ST_HMIX,
    ST_TAIL,
    ST_AVAL,
    ST_EMIT
  } wfmh_state_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CHAR_TAB) || (b == CHAR_LF) || (b == CHAR_CR) || (b == CHAR_SPACE);
  endfunction

endpackage

[rtl/wfmh_front.sv]
// Byte intake: whitespace filter, word packing, kept-byte count, command build.
module wfmh_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [31:0]          cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  output logic                 push,
  output wfmh_pkg::wfmh_cmd_t  push_cmd,
  input  logic                 fifo_full
);
  import wfmh_pkg::*;

  logic [31:0] filtered_length;
  logic        in_message;
  logic        first_pending;
  logic [31:0] seed;
  logic [23:0] pending;
  logic [1:0]  pend_cnt;
  logic [31:0] kept;

  logic        start;
  logic        accept;
  logic        keep;
  logic [23:0] eff_pend;
  logic [1:0]  eff_cnt;
  logic [31:0] eff_kept;
  logic [31:0] eff_seed;
  logic        eff_first;
  logic [23:0] pending_next;
  logic [1:0]  pend_cnt_next;
  logic [31:0] kept_next;
  logic        has_word;

  assign in_ready = !fifo_full;
  assign accept   = in_valid && in_ready;
  assign start    = !in_message;
  assign keep     = !is_blank(in_byte);

  always_comb begin
    eff_pend  = start ? 24'd0 : pending;
    eff_cnt   = start ? 2'd0 : pend_cnt;
    eff_kept  = start ? 32'd0 : kept;
    eff_seed  = start ? (32'd1 ^ filtered_length) : seed;
    eff_first = start ? 1'b1 : first_pending;
    kept_next = eff_kept + {31'd0, keep};
    has_word  = keep && (eff_cnt == 2'd3);

    pending_next  = eff_pend;
    pend_cnt_next = eff_cnt;
    if (has_word) begin
      pending_next  = 24'd0;
      pend_cnt_next = 2'd0;
    end else if (keep) begin
      pend_cnt_next = eff_cnt + 2'd1;
      case (eff_cnt)
        2'd0:    pending_next = {eff_pend[23:8], in_byte};
        2'd1:    pending_next = {eff_pend[23:16], in_byte, eff_pend[7:0]};
        2'd2:    pending_next = {in_byte, eff_pend[15:0]};
        default: pending_next = eff_pend;
      endcase
    end

    push_cmd.start    = eff_first;
    push_cmd.seed     = eff_seed;
    push_cmd.has_word = has_word;
    push_cmd.word     = {in_byte, eff_pend};
    push_cmd.is_final = in_last;
    push_cmd.tail     = pending_next;
    push_cmd.tail_cnt = pend_cnt_next;
    push_cmd.mismatch = (kept_next != filtered_length);
  end

  assign push = accept && (has_word || in_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_length <= 32'd0;
    end else if (cfg_wr_en) begin
      filtered_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_message    <= 1'b0;
      first_pending <= 1'b0;
      pending       <= 24'd0;
      pend_cnt      <= 2'd0;
      kept          <= 32'd0;
    end else if (accept) begin
      in_message    <= !in_last;
      first_pending <= push ? 1'b0 : eff_first;
      kept          <= kept_next;
      if (in_last) begin
        pending  <= 24'd0;
        pend_cnt <= 2'd0;
      end else begin
        pending  <= pending_next;
        pend_cnt <= pend_cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seed <= eff_seed;
    end
  end

endmodule

[rtl/wfmh_fifo.sv]
// Short command queue between the byte front end and the hash engine.
module wfmh_fifo #(
  parameter int DEPTH = wfmh_pkg::CMD_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  wfmh_pkg::wfmh_cmd_t  push_cmd,
  input  logic                 pop,
  output wfmh_pkg::wfmh_cmd_t  pop_cmd,
  output logic                 full,
  output logic                 empty
);
  import wfmh_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  wfmh_cmd_t     entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("command pushed into full queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue count out of range");
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (empty && !$past(rst) && $past(do_push)) |-> $past(do_pop) || $past(count) != '0)
    else $error("queue empty right after a lone push");

endmodule

[rtl/wfmh_back.sv]
// Hash engine: one shared 32x32 multiplier stepped through mix, tail and finalization.
module wfmh_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fifo_empty,
  input  wfmh_pkg::wfmh_cmd_t  pop_cmd,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_hash,
  output logic                 out_mismatch
);
  import wfmh_pkg::*;

  wfmh_state_t state;
  wfmh_state_t state_next;
  wfmh_cmd_t   cmd;
  logic [31:0] h;
  logic [31:0] k;
  logic [31:0] mul_a;
  logic [31:0] prod;
  logic [31:0] fin_hash;
  logic        slot_free;

  assign prod      = mul_a * MIX_MUL;
  assign fin_hash  = h ^ (h >> FIN_SHIFT_B);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    case (state)
      ST_K1:   mul_a = k;
      ST_K2:   mul_a = k ^ (k >> MIX_SHIFT);
      ST_HMIX: mul_a = h;
      ST_TAIL: mul_a = h ^ {8'd0, cmd.tail};
      ST_AVAL: mul_a = h ^ (h >> FIN_SHIFT_A);
      default: mul_a = k;
    endcase
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!fifo_empty) begin
          pop = 1'b1;
          if (pop_cmd.has_word) begin
            state_next = ST_K1;
          end else if (pop_cmd.tail_cnt != 2'd0) begin
            state_next = ST_TAIL;
          end else begin
            state_next = ST_AVAL;
          end
        end
      end
      ST_K1:   state_next = ST_K2;
      ST_K2:   state_next = ST_HMIX;
      ST_HMIX: begin
        if (!cmd.is_final) begin
          state_next = ST_IDLE;
        end else if (cmd.tail_cnt != 2'd0) begin
          state_next = ST_TAIL;
        end else begin
          state_next = ST_AVAL;
        end
      end
      ST_TAIL: state_next = ST_AVAL;
      ST_AVAL: state_next = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h <= 32'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!fifo_empty && pop_cmd.start) begin
            h <= pop_cmd.seed;
          end
        end
        ST_HMIX: h <= prod ^ k;
        ST_TAIL: h <= prod;
        ST_AVAL: h <= prod;
        ST_EMIT: begin
          if (slot_free) begin
            h <= fin_hash;
          end
        end
        default: h <= h;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!fifo_empty) begin
          cmd <= pop_cmd;
          k   <= pop_cmd.word;
        end
      end
      ST_K1:   k <= prod;
      ST_K2:   k <= prod;
      default: k <= k;
    endcase
  end

  // output register: result waits here while the engine takes the next word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && slot_free) begin
      out_hash     <= fin_hash;
      out_mismatch <= cmd.mismatch;
    end
  end

  a_emit_after_aval: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && $past(state) != ST_EMIT) |-> $past(state) == ST_AVAL)
    else $error("emit reached without avalanche step");
  a_rose_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EMIT)
    else $error("result raised outside emit");
  a_tail_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_TAIL |-> cmd.tail_cnt != 2'd0 && cmd.is_final)
    else $error("tail step with no tail bytes");
  a_pop_idle_only: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == ST_IDLE && !fifo_empty)
    else $error("pop outside idle");

endmodule

[rtl/whitespace_filtered_murmur2_hash.sv]
// Top level: whitespace-filtered MurmurHash2 over a byte stream.
// After the last byte is taken, the closing command waits behind any work already queued.
// Throughput: the front takes one byte per cycle while the command queue has room; the
// hash engine pops a command only when idle, steps a word through K1, K2 and HMIX (one shared
// multiplier used three times); a closing command adds TAIL if bytes remain, then AVAL, EMIT.
// Reset (rst, synchronous): clears filtered_length, queue, engine and message state.
module whitespace_filtered_murmur2_hash #(
  parameter int FIFO_DEPTH = wfmh_pkg::CMD_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,   // filtered_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] hash_value
  output logic [0:0]  m_axis_tuser   // [0] length_mismatch
);
  import wfmh_pkg::*;

  wfmh_cmd_t push_cmd;
  wfmh_cmd_t pop_cmd;
  logic      push;
  logic      pop;
  logic      fifo_full;
  logic      fifo_empty;
  logic      mismatch;

  wfmh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_byte     (s_axis_tdata),
    .in_last     (s_axis_tlast),
    .push        (push),
    .push_cmd    (push_cmd),
    .fifo_full   (fifo_full)
  );

  wfmh_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  wfmh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .fifo_empty   (fifo_empty),
    .pop_cmd      (pop_cmd),
    .pop          (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_hash     (m_axis_tdata),
    .out_mismatch (mismatch)
  );

  assign m_axis_tuser = mismatch;

endmodule

[tb/whitespace_filtered_murmur2_hash_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the whitespace-filtered MurmurHash2 byte stream hasher.
module whitespace_filtered_murmur2_hash_tb;
  import wfmh_pkg::*;

  localparam int RAND_ITEMS  = 1900;
  localparam int CALM_AT     = RAND_ITEMS * 85 / 100;
  localparam int SETTLE      = 16;
  localparam int LONG_HOLD   = 400;
  localparam int HOLD_PHASE  = 8;
  localparam int HOLD_MSGS   = 12;
  localparam int STALL_LIMIT = 4000;
  localparam int DIR_N       = 25;

  typedef struct packed {
    logic [31:0] hash;
    logic        mismatch;
  } digest_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_word_t;

  typedef struct packed {
    logic        wr_cfg;
    logic [31:0] cfg;
    logic [7:0]  data;
    logic        last;
    logic        gold;
    logic [31:0] gold_hash;
    logic        gold_mis;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] hash_value
  logic [0:0]  m_axis_tuser;        // [0] length_mismatch

  // mirror of the hashing state
  logic [31:0] len_reg  = '0;
  logic [31:0] acc      = '0;
  logic [23:0] tail     = '0;
  logic [1:0]  tail_cnt = '0;
  logic [31:0] kept     = '0;
  logic        in_msg   = 1'b0;

  digest_t  digest_q[$];
  dir_row_t dir_rows [DIR_N];
  int       bad_count    = 0;
  int       quiet_cycles = 0;
  int       rand_sent    = 0;
  bit       calm         = 1'b0;
  bit       hold_go      = 1'b0;
  bit       held_off     = 1'b0;

  whitespace_filtered_murmur2_hash dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_white(input logic [7:0] b);
    return b == CHAR_TAB || b == CHAR_LF || b == CHAR_CR || b == CHAR_SPACE;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return CHAR_TAB;
      1: return CHAR_LF;
      2: return CHAR_CR;
      default: return CHAR_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 9) < 2) return pick_blank();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic mix_word(input logic [31:0] w);
    logic [31:0] k;
    k   = w * MIX_MUL;
    k   = k ^ (k >> MIX_SHIFT);
    k   = k * MIX_MUL;
    acc = acc * MIX_MUL;
    acc = acc ^ k;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic last,
                             output bit emits, output digest_t d);
    logic [31:0] h;
    emits = 1'b0;
    d     = '0;
    if (!in_msg) begin
      acc      = 32'd1 ^ len_reg;
      tail     = '0;
      tail_cnt = '0;
      kept     = '0;
      in_msg   = 1'b1;
    end
    if (!is_white(b)) begin
      kept = kept + 32'd1;
      if (tail_cnt == 2'd3) begin
        mix_word({b, tail});
        tail     = '0;
        tail_cnt = '0;
      end else begin
        tail[8 * tail_cnt +: 8] = b;
        tail_cnt = tail_cnt + 2'd1;
      end
    end
    if (last) begin
      h = acc;
      if (tail_cnt != 2'd0) begin
        h = h ^ {8'h00, tail};
        h = h * MIX_MUL;
      end
      h = h ^ (h >> FIN_SHIFT_A);
      h = h * MIX_MUL;
      h = h ^ (h >> FIN_SHIFT_B);
      emits      = 1'b1;
      d.hash     = h;
      d.mismatch = (kept != len_reg);
      acc        = h;
      tail       = '0;
      tail_cnt   = '0;
      in_msg     = 1'b0;
    end
  endtask

  task automatic offer_byte(input logic [7:0] b, input logic last,
                            input logic use_gold, input digest_t gold);
    bit      emits;
    digest_t d;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    absorb_byte(b, last, emits, d);
    if (emits) digest_q.push_back(use_gold ? gold : d);
  endtask

  // register changes only once every hash is out and the engine has settled
  task automatic drain_and_write(input logic [31:0] v);
    s_axis_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    len_reg = v;
    cfg_wr_en <= 1'b0;
  endtask

  // output side: random stalls, one long hold-off so the front end backs up
  initial begin
    forever begin
      if (hold_go && !held_off) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    digest_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (digest_q.size() == 0) begin
        if (bad_count < 10)
          $display("unexpected hash word: hash %h mismatch %b", m_axis_tdata, m_axis_tuser[0]);
        bad_count++;
      end else begin
        want = digest_q.pop_front();
        if (m_axis_tdata !== want.hash || m_axis_tuser[0] !== want.mismatch) begin
          if (bad_count < 10)
            $display("hash mismatch: expected %h/%b got %h/%b",
                     want.hash, want.mismatch, m_axis_tdata, m_axis_tuser[0]);
          bad_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_wr_en || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    byte_word_t  phase_words[$];
    logic [7:0]  b;
    logic [31:0] first_kept;
    logic [31:0] len_pick;
    logic [31:0] cnt;
    int          n_msgs;
    int          msg_len;
    int          phase_no;
    bit          all_blank;

    // wr_cfg, cfg, data, last, gold, gold_hash, gold_mis
    dir_rows = '{
      // only a space right after reset: empty message, seed 1
      {1'b0, 32'h0,        8'h20, 1'b1, 1'b1, 32'h5bd15e36, 1'b0},
      {1'b0, 32'h0,        8'h61, 1'b0, 1'b0, 32'h0, 1'b0},
      {1'b0, 32'h0,        8'h00, 1'b0, 1'b0, 32'h0, 1'b0},
      {1'b0, 32'h0,        8'hff, 1'b0, 1'b0, 32'h0, 1'b0},
      {1'b0, 32'h0,        8'h09, 1'b0, 1'b0, 32'h0, 1'b0},
      {1'b0, 32'h0,        8'h0a, 1'b0, 1'b0, 32'h0, 1'b0},
      {1'b0, 32'h0,        8'h0d, 1'b0, 1'b0, 32'h0, 1'b0},
      {1'b0, 32'h0,        8'h20, 1'b0, 1'b0, 32'h0, 1'b0},
      {1'b0, 32'h0,        8'h7f, 1'b0, 1'b0, 32'h0, 1'b0},
      {1'b0, 32'h0,        8'h80, 1'b0, 1'b0, 32'h0, 1'b0},
      // blank last byte with one tail byte pending
      {1'b0, 32'h0,        8'h0a, 1'b1, 1'b0, 32'h0, 1'b0},
      {1'b1, 32'd5,        8'h68, 1'b0, 1'b0, 32'h0, 1'b0},
      {1'b0, 32'h0,        8'h65, 1'b0, 1'b0, 32'h0, 1'b0},
      {1'b0, 32'h0,        8'h6c, 1'b0, 1'b0, 32'h0, 1'b0},
      {1'b0, 32'h0,        8'h6c, 1'b0, 1'b0, 32'h0, 1'b0},
      {1'b0, 32'h0,        8'h6f, 1'b1, 1'b0, 32'h0, 1'b0},
      {1'b1, 32'hffffffff, 8'hff, 1'b1, 1'b0, 32'h0, 1'b0},
      {1'b1, 32'd4,        8'h01, 1'b0, 1'b0, 32'h0, 1'b0},
      {1'b0, 32'h0,        8'h02, 1'b0, 1'b0, 32'h0, 1'b0},
      {1'b0, 32'h0,        8'h03, 1'b0, 1'b0, 32'h0, 1'b0},
      {1'b0, 32'h0,        8'h04, 1'b1, 1'b0, 32'h0, 1'b0},
      {1'b0, 32'h0,        8'h09, 1'b1, 1'b0, 32'h0, 1'b0},
      {1'b1, 32'd3,        8'hfe, 1'b0, 1'b0, 32'h0, 1'b0},
      {1'b0, 32'h0,        8'h20, 1'b0, 1'b0, 32'h0, 1'b0},
      {1'b0, 32'h0,        8'h11, 1'b0, 1'b0, 32'h0, 1'b0}
    };
    // the last directed row must close its message
    dir_rows[DIR_N - 1].last = 1'b1;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) begin
      if (dir_rows[i].wr_cfg) drain_and_write(dir_rows[i].cfg);
      offer_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].gold,
                 {dir_rows[i].gold_hash, dir_rows[i].gold_mis});
    end

    phase_no = 0;
    while (rand_sent < RAND_ITEMS) begin
      phase_words.delete();
      first_kept = '0;
      // hold phase: many short messages so finished hashes pile up behind the output
      n_msgs = (phase_no == HOLD_PHASE) ? HOLD_MSGS : $urandom_range(1, 4);
      for (int m = 0; m < n_msgs; m++) begin
        if (phase_no == HOLD_PHASE)
          msg_len = 3;
        else if ($urandom_range(0, 9) == 0)
          msg_len = $urandom_range(13, 64);
        else
          msg_len = $urandom_range(1, 12);
        all_blank = ($urandom_range(0, 11) == 0);
        cnt = '0;
        for (int j = 0; j < msg_len; j++) begin
          b = all_blank ? pick_blank() : rand_byte();
          if (!is_white(b)) cnt = cnt + 32'd1;
          phase_words.push_back({b, j == msg_len - 1});
        end
        if (m == 0) first_kept = cnt;
      end

      case ($urandom_range(0, 5))
        0: len_pick = 32'h0;
        1: len_pick = 32'hffffffff;
        2: len_pick = $urandom;
        default: len_pick = first_kept;
      endcase
      drain_and_write(len_pick);
      if (phase_no == HOLD_PHASE) hold_go = 1'b1;

      foreach (phase_words[w]) begin
        offer_byte(phase_words[w].data, phase_words[w].last, 1'b0, '0);
        rand_sent++;
        calm = (rand_sent >= CALM_AT);
      end
      phase_no++;
    end

    s_axis_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (bad_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[whitespace_filtered_murmur2_hash.f]
rtl/wfmh_pkg.sv
rtl/wfmh_front.sv
rtl/wfmh_fifo.sv
rtl/wfmh_back.sv
rtl/whitespace_filtered_murmur2_hash.sv
tb/whitespace_filtered_murmur2_hash_tb.sv
